// ----- hdl/magic_header_packet_deframer_macros.svh -----
// Assertion macros used by the deframer top level.
`ifndef MAGIC_HEADER_PACKET_DEFRAMER_MACROS_SVH
`define MAGIC_HEADER_PACKET_DEFRAMER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mhd_pkg.sv -----
// Package with the types and constants of the magic header packet deframer.
package mhd_pkg;

    localparam int HDR_BYTES       = 20;
    localparam int MAGIC_BYTES     = 4;
    localparam int NCELLS          = HDR_BYTES - 1;
    localparam int LENGTH_BITS_DEF = 24;
    localparam int CFG_BITS        = 24;
    localparam int DIM_BITS        = 11;

    localparam logic [15:0]         DIM_MAX       = 16'd1024;
    localparam logic [31:0]         LEN_MIN       = 32'd4;
    localparam logic [CFG_BITS-1:0] MAX_LEN_RESET = 24'd262144;

    localparam logic [MAGIC_BYTES-1:0][7:0] MAGIC = {8'h56, 8'h4D, 8'h50, 8'h46};

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr_bytes;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_cell_data;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

    typedef struct packed {
        logic                ok;
        logic [DIM_BITS-1:0] width;
        logic [DIM_BITS-1:0] height;
        logic [31:0]         seq;
        logic [31:0]         len;
    } t_hdr_info;

    typedef struct packed {
        logic                kind;
        logic [DIM_BITS-1:0] frame_width;
        logic [DIM_BITS-1:0] frame_height;
        logic [31:0]         frame_sequence;
        logic [CFG_BITS-1:0] payload_length;
        logic [7:0]          payload_byte;
        logic                last;
    } t_result;

endpackage

// ----- hdl/magic_header_packet_deframer.sv -----
// Top level of the magic header packet deframer.
//
// Received bytes enter on the input channel (i_in_valid, o_in_stall, i_byte_in),
// one per unstalled cycle. While hunting, each byte shifts into a chain of 19 byte
// cells; together with the arriving byte they form a 20-byte window which is
// checked for the magic "FPMV", width and height of 1 to 1024 and a length of
// 4 up to the maximum held in the configuration register (i_cfg_we, i_cfg_data).
// A window that passes yields one header word and clears the chain; the next
// bytes then leave as payload words, the final one flagged by o_last.
// Results leave on the output channel (o_out_valid, i_out_stall) from registers,
// and a new byte is taken in every cycle while o_in_stall is low. A two-entry
// output buffer absorbs a stalled receiver: o_in_stall rises only when both
// entries are full, and it is a registered signal.
// Synchronous reset empties the chain and the output buffer, returns the block
// to hunting and sets the maximum payload length to 262144.
module magic_header_packet_deframer
    import mhd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_byte_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_kind,
    output logic [DIM_BITS-1:0] o_frame_width,
    output logic [DIM_BITS-1:0] o_frame_height,
    output logic [31:0]         o_frame_sequence,
    output logic [CFG_BITS-1:0] o_payload_length,
    output logic [7:0]          o_payload_byte,
    output logic                o_last
);

    logic [CFG_BITS-1:0]    r_max_len;
    logic                   r_in_payload;
    logic                   n_in_payload;
    logic [LENGTH_BITS-1:0] r_bytes_left;
    logic [LENGTH_BITS-1:0] n_bytes_left;
    logic                   r_out_valid;
    t_result                r_out;
    logic                   r_sk_valid;
    t_result                r_sk;

    t_cell_data             cell_q [NCELLS];
    t_cell_ctrl             cell_ctrl;
    t_hdr_bytes             window;
    t_hdr_info              hdr;
    logic                   in_take;
    logic                   out_free;
    logic                   hdr_hit;
    logic                   res_valid;
    t_result                res;
    logic                   cells_busy;

    assign o_in_stall = r_sk_valid;
    assign in_take    = i_in_valid && !r_sk_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Chain of byte cells: cell 0 holds the newest byte.
    for (genvar j = 0; j < NCELLS; j++) begin : g_cell
        t_cell_data prev;
        if (j == 0) begin : g_head
            assign prev = '{valid: 1'b1, data: i_byte_in};
        end else begin : g_link
            assign prev = cell_q[j-1];
        end
        mhd_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (cell_ctrl),
            .i_prev (prev),
            .o_cell (cell_q[j])
        );
    end

    always_comb begin
        window[HDR_BYTES-1] = i_byte_in;
        cells_busy          = 1'b0;
        for (int k = 0; k < NCELLS; k++) begin
            window[k]  = cell_q[NCELLS-1-k].data;
            cells_busy = cells_busy | cell_q[k].valid;
        end
    end

    mhd_hdr_check #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_hdr_check (
        .i_bytes  (window),
        .i_full   (cell_q[NCELLS-1].valid),
        .i_max_len(r_max_len),
        .o_info   (hdr)
    );

    always_comb begin
        hdr_hit         = in_take && !r_in_payload && hdr.ok;
        cell_ctrl.shift = in_take && !r_in_payload;
        cell_ctrl.clear = hdr_hit;
        n_in_payload    = r_in_payload;
        n_bytes_left    = r_bytes_left;
        res_valid       = 1'b0;
        res             = '0;
        if (in_take && r_in_payload) begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = i_byte_in;
            res.last         = (r_bytes_left == LENGTH_BITS'(1));
            n_bytes_left     = r_bytes_left - LENGTH_BITS'(1);
            if (res.last) begin
                n_in_payload = 1'b0;
            end
        end else if (hdr_hit) begin
            res_valid          = 1'b1;
            res.kind           = KIND_HEADER;
            res.frame_width    = hdr.width;
            res.frame_height   = hdr.height;
            res.frame_sequence = hdr.seq;
            res.payload_length = hdr.len[CFG_BITS-1:0];
            n_in_payload       = 1'b1;
            n_bytes_left       = hdr.len[LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= MAX_LEN_RESET;
            r_in_payload <= 1'b0;
            r_bytes_left <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            r_in_payload <= n_in_payload;
            r_bytes_left <= n_bytes_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (out_free) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_valid) begin
                r_out <= r_sk;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_sk <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_frame_width    = r_out.frame_width;
    assign o_frame_height   = r_out.frame_height;
    assign o_frame_sequence = r_out.frame_sequence;
    assign o_payload_length = r_out.payload_length;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_last           = r_out.last;

    `include "magic_header_packet_deframer_macros.svh"

    `MHD_ASSERT_NOW(a_skid_behind_out, r_sk_valid, r_out_valid, "skid entry without output entry")
    `MHD_ASSERT_NOW(a_payload_cells_empty, r_in_payload, !cells_busy, "cells hold bytes in payload")
    `MHD_ASSERT_NOW(a_payload_count, r_in_payload, r_bytes_left != '0, "payload with no bytes left")
    `MHD_ASSERT_NEXT(a_hdr_enters_payload, hdr_hit, r_in_payload && r_out_valid, "header not taken")
    `MHD_ASSERT_NEXT(a_last_leaves_payload, res_valid && res.last, !r_in_payload, "stuck in payload")

endmodule

// ----- hdl/mhd_cell.sv -----
// One byte cell of the header search chain.
module mhd_cell
    import mhd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_cell_data i_prev,
    output t_cell_data o_cell
);

    logic       r_valid;
    logic [7:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_data <= i_prev.data;
        end
    end

    assign o_cell = '{valid: r_valid, data: r_data};

endmodule

// ----- hdl/mhd_hdr_check.sv -----
// Decoding and checking of a 20-byte little-endian header window.
module mhd_hdr_check
    import mhd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  t_hdr_bytes          i_bytes,
    input  logic                i_full,
    input  logic [CFG_BITS-1:0] i_max_len,
    output t_hdr_info           o_info
);

    localparam logic [32:0] LEN_MASK = (33'd1 << LENGTH_BITS) - 33'd1;

    logic [15:0] w;
    logic [15:0] h;
    logic [31:0] len;
    logic        magic_ok;
    logic        dims_ok;
    logic        len_ok;

    always_comb begin
        w   = {i_bytes[5], i_bytes[4]};
        h   = {i_bytes[7], i_bytes[6]};
        len = {i_bytes[19], i_bytes[18], i_bytes[17], i_bytes[16]};
        magic_ok = 1'b1;
        for (int k = 0; k < MAGIC_BYTES; k++) begin
            if (i_bytes[k] != MAGIC[k]) begin
                magic_ok = 1'b0;
            end
        end
        dims_ok = (w != 16'd0) && (w <= DIM_MAX) && (h != 16'd0) && (h <= DIM_MAX);
        len_ok  = (len >= LEN_MIN) && (len <= {8'd0, i_max_len})
                  && ({1'b0, len} <= LEN_MASK);
        o_info.ok     = i_full && magic_ok && dims_ok && len_ok;
        o_info.width  = w[DIM_BITS-1:0];
        o_info.height = h[DIM_BITS-1:0];
        o_info.seq    = {i_bytes[11], i_bytes[10], i_bytes[9], i_bytes[8]};
        o_info.len    = len;
    end

endmodule

// ----- sim/magic_header_packet_deframer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the magic header packet deframer with its own frame predictor.
module magic_header_packet_deframer_tb;
    import mhd_pkg::*;

    localparam int     QUIET_LIMIT = 1000;
    localparam longint LEN_CAP     = (64'd1 << LENGTH_BITS_DEF) - 1;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [7:0]          i_byte_in  = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_kind;
    logic [DIM_BITS-1:0] o_frame_width;
    logic [DIM_BITS-1:0] o_frame_height;
    logic [31:0]         o_frame_sequence;
    logic [CFG_BITS-1:0] o_payload_length;
    logic [7:0]          o_payload_byte;
    logic                o_last;

    logic [7:0]          hunt_bytes [HDR_BYTES];
    int unsigned         hunt_fill = 0;
    bit                  in_packet = 1'b0;
    logic [CFG_BITS-1:0] bytes_left = '0;
    logic [CFG_BITS-1:0] max_len = MAX_LEN_RESET;
    t_result             frame_results [$];

    int unsigned errors = 0;
    int unsigned bytes_sent = 0;
    int unsigned headers_taken = 0;
    int unsigned windows_dropped = 0;
    int unsigned payload_seen = 0;
    bit          send_gaps = 1'b1;
    bit          recv_gaps = 1'b1;
    bit          gaps_fixed = 1'b0;
    int unsigned stall_left = 0;

    magic_header_packet_deframer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_byte_in        (i_byte_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_frame_width    (o_frame_width),
        .o_frame_height   (o_frame_height),
        .o_frame_sequence (o_frame_sequence),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void realign_hunt();
        int unsigned p;
        int unsigned k;
        int unsigned n;
        bit          ok;
        for (p = 0; p < hunt_fill; p++) begin
            ok = 1'b1;
            for (k = 0; k < MAGIC_BYTES && p + k < hunt_fill; k++) begin
                if (hunt_bytes[p + k] != MAGIC[k]) begin
                    ok = 1'b0;
                    break;
                end
            end
            if (ok) break;
        end
        if (p > 0) begin
            for (n = 0; n + p < hunt_fill; n++) hunt_bytes[n] = hunt_bytes[n + p];
            hunt_fill -= p;
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        logic [15:0] w;
        logic [15:0] h;
        logic [31:0] seq;
        logic [31:0] len;
        t_result     r;
        r = '0;
        if (in_packet) begin
            bytes_left     = bytes_left - 1'b1;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.last         = (bytes_left == 0);
            if (bytes_left == 0) in_packet = 1'b0;
            frame_results.push_back(r);
            payload_seen++;
            return;
        end
        hunt_bytes[hunt_fill] = b;
        hunt_fill++;
        realign_hunt();
        if (hunt_fill < HDR_BYTES) return;
        w   = {hunt_bytes[5], hunt_bytes[4]};
        h   = {hunt_bytes[7], hunt_bytes[6]};
        seq = {hunt_bytes[11], hunt_bytes[10], hunt_bytes[9], hunt_bytes[8]};
        len = {hunt_bytes[19], hunt_bytes[18], hunt_bytes[17], hunt_bytes[16]};
        if (w < 1 || w > DIM_MAX || h < 1 || h > DIM_MAX || len < LEN_MIN ||
            len > {8'd0, max_len} || longint'(len) > LEN_CAP) begin
            for (int i = 0; i < HDR_BYTES - 1; i++) hunt_bytes[i] = hunt_bytes[i + 1];
            hunt_fill = HDR_BYTES - 1;
            realign_hunt();
            windows_dropped++;
            return;
        end
        hunt_fill        = 0;
        in_packet        = 1'b1;
        bytes_left       = len[CFG_BITS-1:0];
        r.kind           = KIND_HEADER;
        r.frame_width    = w[DIM_BITS-1:0];
        r.frame_height   = h[DIM_BITS-1:0];
        r.frame_sequence = seq;
        r.payload_length = len[CFG_BITS-1:0];
        frame_results.push_back(r);
        headers_taken++;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_results.size() == 0) begin
                $error("result word with nothing expected (kind %0d)", o_kind);
                errors++;
            end else begin
                want = frame_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("frame_width", 32'(want.frame_width), 32'(o_frame_width));
                check_field("frame_height", 32'(want.frame_height), 32'(o_frame_height));
                check_field("frame_sequence", want.frame_sequence, o_frame_sequence);
                check_field("payload_length", 32'(want.payload_length),
                            32'(o_payload_length));
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (recv_gaps && $urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $error("no word moved for %0d cycles", QUIET_LIMIT);
        $display("magic_header_packet_deframer: mismatch");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = (send_gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (frame_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_max(input logic [CFG_BITS-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        max_len = value;
    endtask

    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 3) == 0) return MAGIC[$urandom_range(0, MAGIC_BYTES - 1)];
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 16'd1;
            1: return DIM_MAX;
            default: return 16'($urandom_range(1, 1024));
        endcase
    endfunction

    function automatic logic [31:0] pick_len(input int unsigned cap);
        int unsigned upper;
        upper = (max_len < cap) ? max_len : cap;
        if (upper < LEN_MIN) return LEN_MIN;
        return $urandom_range(LEN_MIN, upper);
    endfunction

    task automatic send_header(input logic [15:0] w, input logic [15:0] h,
                               input logic [31:0] seq, input logic [31:0] len,
                               input logic [31:0] spare);
        t_hdr_bytes hb;
        hb = {len, spare, seq, h, w, MAGIC};
        for (int i = 0; i < HDR_BYTES; i++) send_byte(hb[i]);
    endtask

    task automatic finish_packet();
        while (in_packet) send_byte(data_byte());
    endtask

    task automatic test_header_limits();
        send_byte(MAGIC[0]);
        send_byte(MAGIC[1]);
        send_byte(MAGIC[0]);
        send_header(16'd1, 16'd1, 32'd0, LEN_MIN, $urandom);
        finish_packet();
        send_header(DIM_MAX, DIM_MAX, 32'hFFFF_FFFF, 32'd5, 32'hFFFF_FFFF);
        for (int i = 0; i < MAGIC_BYTES; i++) send_byte(MAGIC[i]);
        finish_packet();
        send_header(16'd0, 16'd5, 32'd1, 32'd8, $urandom);
        send_header(16'd1025, 16'd5, 32'd2, 32'd8, $urandom);
        send_header(16'd5, 16'd0, 32'd3, 32'd8, $urandom);
        send_header(16'd5, 16'd1025, 32'd4, 32'd8, $urandom);
        send_header(16'd5, 16'd5, 32'd5, 32'd3, $urandom);
        send_header(16'd5, 16'd5, 32'd6, MAX_LEN_RESET + 1, $urandom);
        send_header(16'hFFFF, 16'hFFFF, 32'd7, 32'd0, 32'd0);
        send_byte(8'h00);
        send_header(16'd7, 16'd9, 32'd8, 32'd6, $urandom);
        finish_packet();
    endtask

    // A bad header carries a full magic in its spare field; the search must restart there.
    task automatic test_resync();
        logic [95:0] tail;
        tail = {32'd6, 32'($urandom), 32'h1234_5678};
        send_header(16'd0, 16'd1, 32'd0, {16'd3, 16'd2}, MAGIC);
        for (int i = 0; i < 12; i++) send_byte(tail[8*i +: 8]);
        finish_packet();
    endtask

    task automatic test_max_setting();
        send_header(16'd2, 16'd2, 32'd1, 32'd12, $urandom);
        repeat (5) send_byte(data_byte());
        set_max(24'd4);
        finish_packet();
        send_header(16'd3, 16'd3, 32'd2, 32'd4, $urandom);
        finish_packet();
        send_header(16'd3, 16'd3, 32'd3, 32'd5, $urandom);
        set_max(24'd3);
        send_header(16'd3, 16'd3, 32'd4, 32'd4, $urandom);
        set_max(24'hFF_FFFF);
        send_header(16'd4, 16'd4, 32'd5, 32'h0100_0000, $urandom);
        send_header(16'd4, 16'd4, 32'd6, 32'hFFFF_FFFF, $urandom);
        send_header(16'd4, 16'd4, 32'd7, 32'd300, $urandom);
        finish_packet();
    endtask

    task automatic run_random(input logic [CFG_BITS-1:0] limit, input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        logic [31:0] len;
        set_max(limit);
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            if (!gaps_fixed && $urandom_range(0, 7) == 0) begin
                send_gaps = $urandom_range(0, 2) != 0;
                recv_gaps = $urandom_range(0, 2) != 0;
            end
            case (pick)
                14: send_header($urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1025, 65535)),
                                pick_dim(), $urandom, pick_len(24), $urandom);
                15: send_header(pick_dim(),
                                $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1025, 65535)),
                                $urandom, pick_len(24), $urandom);
                16: send_header(pick_dim(), pick_dim(), $urandom, $urandom_range(0, 3), $urandom);
                17: begin
                    if (max_len < 24'hFF_FFFF) begin
                        len = max_len + 1 + $urandom_range(0, 100);
                    end else begin
                        len = 32'h0100_0000 | $urandom;
                    end
                    send_header(pick_dim(), pick_dim(), $urandom, len, $urandom);
                end
                18, 19: repeat ($urandom_range(1, 30)) send_byte(data_byte());
                default: begin
                    if (pick == 13) begin
                        len = pick_len(300);
                    end else if (pick == 12) begin
                        len = pick_len(max_len);
                        if (max_len > 300) len = pick_len(24);
                    end else begin
                        len = pick_len(24);
                    end
                    send_header(pick_dim(), pick_dim(), $urandom, len, $urandom);
                end
            endcase
            finish_packet();
        end
    endtask

    task automatic test_random_settings();
        run_random(24'hFF_FFFF, 200);
        run_random(24'd4, 200);
        run_random(24'($urandom_range(5, 300)), 200);
    endtask

    task automatic test_steady_flow();
        settle();
        gaps_fixed = 1'b1;
        send_gaps  = 1'b0;
        recv_gaps  = 1'b0;
        run_random(MAX_LEN_RESET, 200);
    endtask

    initial begin
        foreach (hunt_bytes[i]) hunt_bytes[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_limits();
        test_resync();
        test_max_setting();
        test_random_settings();
        test_steady_flow();
        settle();
        $display("Sent %0d bytes: %0d headers accepted, %0d header windows rejected.",
                 bytes_sent, headers_taken, windows_dropped);
        $display("Checked %0d payload bytes under maximum lengths from 3 to 16777215.",
                 payload_seen);
        if (errors == 0) begin
            $display("magic_header_packet_deframer: match");
        end else begin
            $display("magic_header_packet_deframer: mismatch");
        end
        $finish;
    end

endmodule
